>>> rtl/ipv4hc_pkg.sv
// Shared definitions for the IPv4 header receive check.
// Holds the verdict codes, the field widths and the fixed comparison values.
// Depends on nothing; the top level refers to it by scoped names.
`default_nettype none

package ipv4hc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned SumW   = 16;
  localparam int unsigned NibW   = 4;

  localparam logic [AddrW-1:0] BroadcastAddr = 32'hffff_ffff;
  localparam logic [SumW-1:0]  SumAllOnes    = 16'hffff;
  localparam logic [LenW-1:0]  LenMax        = 16'hffff;
  localparam logic [NibW-1:0]  VersionIpv4   = 4'd4;
  localparam logic [NibW-1:0]  MinHeaderWords = 4'd5;

  // Byte positions of the header fields that are captured.
  localparam logic [LenW-1:0] PosFirst    = 16'd0;
  localparam logic [LenW-1:0] PosTtl      = 16'd8;
  localparam logic [LenW-1:0] PosDestFirst = 16'd16;
  localparam logic [LenW-1:0] PosDestLast  = 16'd19;

  typedef enum logic [2:0] {
    VERDICT_ACCEPT    = 3'd0,
    VERDICT_VERSION   = 3'd1,
    VERDICT_HDR_LEN   = 3'd2,
    VERDICT_TTL       = 3'd3,
    VERDICT_DEST      = 3'd4,
    VERDICT_CHECKSUM  = 3'd5,
    VERDICT_TRUNCATED = 3'd6
  } verdict_t;

  typedef struct packed {
    verdict_t          verdict;
    logic [LenW-1:0]   packet_length;
  } result_t;

endpackage : ipv4hc_pkg

`default_nettype wire

>>> rtl/ipv4_header_receive_check.sv
// Top level of the IPv4 header receive check: header field capture,
// ones' complement header sum, verdict logic and the result output stage.
// Depends on ipv4hc_pkg for widths, verdict codes and fixed values.
`default_nettype none

// Packet bytes enter one per cycle while in_stall is low, in network order.
// Each byte updates the header state in the cycle it is accepted; the final
// byte of a packet produces one transaction on the result channel, carrying
// the verdict and the byte count, through the result register. The result
// register is backed by a one-entry skid register, so in_stall rises only when
// both hold an unread result, and it comes straight from a flip-flop. The
// local address may be written at any time through the cfg port, which never
// stalls; it is compared only when a packet's final byte arrives.
module ipv4_header_receive_check (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_verdict,
  output logic [15:0]      out_packet_length,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_local_address
);

  localparam int unsigned LenW  = ipv4hc_pkg::LenW;
  localparam int unsigned AddrW = ipv4hc_pkg::AddrW;
  localparam int unsigned SumW  = ipv4hc_pkg::SumW;
  localparam int unsigned NibW  = ipv4hc_pkg::NibW;
  localparam int unsigned ByteW = ipv4hc_pkg::ByteW;

  // Configuration.
  logic [AddrW-1:0] local_addr_r;

  // Per-packet state.
  logic [LenW-1:0]  byte_pos_r,     byte_pos_nxt;
  logic [NibW-1:0]  version_r,      version_nxt;
  logic [NibW-1:0]  hdr_words_r,    hdr_words_nxt;
  logic             ttl_zero_r,     ttl_zero_nxt;
  logic [AddrW-1:0] dest_r,         dest_nxt;
  logic [ByteW-1:0] pend_high_r,    pend_high_nxt;
  logic [SumW-1:0]  sum_r,          sum_nxt;

  // Output stage.
  logic                 out_valid_r;
  ipv4hc_pkg::result_t  out_res_r;
  logic                 skid_valid_r;
  ipv4hc_pkg::result_t  skid_res_r;

  logic                 in_acc;
  logic                 res_valid;
  ipv4hc_pkg::result_t  res;
  logic [NibW+1:0]      hdr_bytes;
  logic                 in_header;
  logic [SumW:0]        sum_wide;
  logic [SumW-1:0]      sum_folded;
  logic [LenW-1:0]      pos_inc;

  assign in_stall  = skid_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign res_valid = in_acc && in_last_byte;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      local_addr_r <= cfg_local_address;
    end
  end

  // Header capture and checksum for the byte being accepted.
  always_comb begin
    version_nxt   = version_r;
    hdr_words_nxt = hdr_words_r;
    ttl_zero_nxt  = ttl_zero_r;
    dest_nxt      = dest_r;
    pend_high_nxt = pend_high_r;
    sum_nxt       = sum_r;

    if (byte_pos_r == ipv4hc_pkg::PosFirst) begin
      version_nxt   = in_data_byte[7:4];
      hdr_words_nxt = in_data_byte[3:0];
    end
    if (byte_pos_r == ipv4hc_pkg::PosTtl) begin
      ttl_zero_nxt = (in_data_byte == '0);
    end
    if (byte_pos_r >= ipv4hc_pkg::PosDestFirst && byte_pos_r <= ipv4hc_pkg::PosDestLast) begin
      dest_nxt = {dest_r[AddrW-ByteW-1:0], in_data_byte};
    end

    // The header length counts 32-bit words; the sum covers that many bytes.
    hdr_bytes  = {hdr_words_nxt, 2'b00};
    in_header  = byte_pos_r < LenW'(hdr_bytes);
    sum_wide   = {1'b0, sum_r} + {1'b0, pend_high_r, in_data_byte};
    sum_folded = sum_wide[SumW-1:0] + SumW'(sum_wide[SumW]);
    if (in_header) begin
      if (!byte_pos_r[0]) begin
        pend_high_nxt = in_data_byte;
      end else begin
        sum_nxt = sum_folded;
      end
    end

    pos_inc = (byte_pos_r == ipv4hc_pkg::LenMax) ? byte_pos_r : byte_pos_r + LenW'(1);
    byte_pos_nxt = pos_inc;

    res.packet_length = pos_inc;
    if (version_nxt != ipv4hc_pkg::VersionIpv4) begin
      res.verdict = ipv4hc_pkg::VERDICT_VERSION;
    end else if (hdr_words_nxt < ipv4hc_pkg::MinHeaderWords) begin
      res.verdict = ipv4hc_pkg::VERDICT_HDR_LEN;
    end else if (pos_inc < LenW'(hdr_bytes)) begin
      res.verdict = ipv4hc_pkg::VERDICT_TRUNCATED;
    end else if (ttl_zero_nxt) begin
      res.verdict = ipv4hc_pkg::VERDICT_TTL;
    end else if (dest_nxt != local_addr_r && dest_nxt != ipv4hc_pkg::BroadcastAddr) begin
      res.verdict = ipv4hc_pkg::VERDICT_DEST;
    end else if (sum_nxt != ipv4hc_pkg::SumAllOnes) begin
      res.verdict = ipv4hc_pkg::VERDICT_CHECKSUM;
    end else begin
      res.verdict = ipv4hc_pkg::VERDICT_ACCEPT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r  <= '0;
      version_r   <= '0;
      hdr_words_r <= '0;
      ttl_zero_r  <= 1'b0;
      dest_r      <= '0;
      pend_high_r <= '0;
      sum_r       <= '0;
    end else if (in_acc) begin
      if (in_last_byte) begin
        // The packet ends here; start the next one from a clean state.
        byte_pos_r  <= '0;
        version_r   <= '0;
        hdr_words_r <= '0;
        ttl_zero_r  <= 1'b0;
        dest_r      <= '0;
        pend_high_r <= '0;
        sum_r       <= '0;
      end else begin
        byte_pos_r  <= byte_pos_nxt;
        version_r   <= version_nxt;
        hdr_words_r <= hdr_words_nxt;
        ttl_zero_r  <= ttl_zero_nxt;
        dest_r      <= dest_nxt;
        pend_high_r <= pend_high_nxt;
        sum_r       <= sum_nxt;
      end
    end
  end

  // Result register with a one-entry skid register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (!out_stall) begin
        skid_valid_r <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid_r && out_stall) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (!out_stall) begin
        out_res_r <= skid_res_r;
      end
    end else if (res_valid) begin
      if (out_valid_r && out_stall) begin
        skid_res_r <= res;
      end else begin
        out_res_r <= res;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_verdict       = out_res_r.verdict;
  assign out_packet_length = out_res_r.packet_length;

endmodule : ipv4_header_receive_check

`default_nettype wire
